/* sv/f2ql_pkg.sv */
// ----------------------------------------------------------------------------
// f2ql_pkg
// Shared types and constants for the float to Q8.24 log2 converter.
// ----------------------------------------------------------------------------
package f2ql_pkg;

    // Field widths
    localparam int MANT_W  = 31;
    localparam int EXP_W   = 11;
    localparam int LOG_W   = 32;

    // Fixed-point layout
    localparam int FRAC_W  = 26;  // interpolation fraction bits of normalized word
    localparam int OUT_FRAC = 24; // Q8.24 fraction bits
    localparam int TAB_FRAC = 8;  // table holds 256*log2(1+k/32)
    localparam int INTERP_SHIFT = FRAC_W - (OUT_FRAC - TAB_FRAC);
    localparam int SEG_W   = 5;   // 32 segments
    localparam int TAB_W   = 9;   // entries up to 256
    localparam int DIFF_W  = 4;   // neighbor differences up to 11
    localparam int LZ_W    = 5;   // shift count 1..31
    localparam int IPART_W = LOG_W - OUT_FRAC;

    // Output code for a zero mantissa
    localparam logic [LOG_W-1:0] ZERO_CODE = 32'h8000_0000;

    // 33-entry log2 table, floor(256*log2(1+k/32))
    localparam logic [TAB_W-1:0] SEG_TABLE [0:32] = '{
        9'd0,   9'd11,  9'd22,  9'd33,  9'd43,  9'd53,  9'd63,  9'd73,
        9'd82,  9'd91,  9'd100, 9'd109, 9'd117, 9'd125, 9'd134, 9'd141,
        9'd149, 9'd157, 9'd164, 9'd172, 9'd179, 9'd186, 9'd193, 9'd200,
        9'd206, 9'd213, 9'd219, 9'd225, 9'd232, 9'd238, 9'd244, 9'd250,
        9'd256
    };

    // Leading-zero result between the counter and the pipeline
    typedef struct packed {
        logic            zero;   // mantissa is all zeros
        logic [LZ_W-1:0] count;  // left shift that sets bit 31 of the word
    } lzc_t;

endpackage

/* sv/float_to_q24_log2.sv */
// ----------------------------------------------------------------------------
// float_to_q24_log2
// log2 of mantissa * 2^exponent in Q8.24 by table lookup with linear
// interpolation over 32 segments.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while m_ready does not hold the output;
//   four pipeline registers (count, normalize, table and multiply, sum)
//   each hold one word, so a stall only backs up.
// Reset: aresetn (synchronous, active low) clears all stage valid bits;
//   data registers are not reset.
// ----------------------------------------------------------------------------
module float_to_q24_log2
    import f2ql_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic        [MANT_W-1:0] s_mantissa,
    input  logic signed [EXP_W-1:0]  s_exponent,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [LOG_W-1:0]  m_log_value
);

    // Stage 1: leading-zero count
    logic                  v1_reg;
    logic                  zero1_reg;
    logic [MANT_W-1:0]     mant1_reg;
    logic [IPART_W-1:0]    exp1_reg;
    logic [LZ_W-1:0]       lz1_reg;
    // Stage 2: normalized segment and fraction
    logic                  v2_reg;
    logic                  zero2_reg;
    logic [SEG_W-1:0]      seg2_reg;
    logic [FRAC_W-1:0]     frac2_reg;
    logic [IPART_W-1:0]    ip2_reg;
    // Stage 3: table base and slope product
    logic                  v3_reg;
    logic                  zero3_reg;
    logic [TAB_W-1:0]      base3_reg;
    logic [DIFF_W+FRAC_W-1:0] prod3_reg;
    logic [IPART_W-1:0]    ip3_reg;
    // Output register
    logic                  m_valid_reg;
    logic [LOG_W-1:0]      log_reg;
    logic [LOG_W-1:0]      log_next;

    logic adv1, adv2, adv3, adv_o;
    lzc_t lz_in;
    logic [31:0]       norm_w;
    logic [TAB_W-1:0]  tab_lo, tab_hi, tab_diff;
    logic [IPART_W-1:0] ip_w;

    // Stage advance chain from the output side
    assign adv_o   = !m_valid_reg || m_ready;
    assign adv3    = !v3_reg || adv_o;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    f2ql_lzc u_lzc (
        .mant (s_mantissa),
        .lz   (lz_in)
    );

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv1)  v1_reg      <= s_valid;
            if (adv2)  v2_reg      <= v1_reg;
            if (adv3)  v3_reg      <= v2_reg;
            if (adv_o) m_valid_reg <= v3_reg;
        end
    end

    // Stage 1 data
    always_ff @(posedge aclk) begin
        if (adv1 && s_valid) begin
            zero1_reg <= lz_in.zero;
            lz1_reg   <= lz_in.count;
            mant1_reg <= s_mantissa;
            exp1_reg  <= s_exponent[IPART_W-1:0];
        end
    end

    // Normalize; integer part 31 + exp - shift, kept mod 2^8
    assign norm_w = {1'b0, mant1_reg} << lz1_reg;
    assign ip_w   = exp1_reg + IPART_W'(31) - {{(IPART_W-LZ_W){1'b0}}, lz1_reg};

    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            zero2_reg <= zero1_reg;
            seg2_reg  <= norm_w[FRAC_W +: SEG_W];
            frac2_reg <= norm_w[FRAC_W-1:0];
            ip2_reg   <= ip_w;
        end
    end

    // Table lookup and slope times fraction
    assign tab_lo   = SEG_TABLE[{1'b0, seg2_reg}];
    assign tab_hi   = SEG_TABLE[{1'b0, seg2_reg} + 6'd1];
    assign tab_diff = tab_hi - tab_lo;

    always_ff @(posedge aclk) begin
        if (adv3 && v2_reg) begin
            zero3_reg <= zero2_reg;
            base3_reg <= tab_lo;
            prod3_reg <= tab_diff[DIFF_W-1:0] * frac2_reg;
            ip3_reg   <= ip2_reg;
        end
    end

    // Final sum, wraps mod 2^32
    always_comb begin
        log_next = {ip3_reg, {OUT_FRAC{1'b0}}}
                 + {{(LOG_W-TAB_W-16){1'b0}}, base3_reg, 16'd0}
                 + {{(LOG_W-(DIFF_W+FRAC_W-INTERP_SHIFT)){1'b0}},
                    prod3_reg[DIFF_W+FRAC_W-1:INTERP_SHIFT]};
        if (zero3_reg) begin
            log_next = ZERO_CODE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_o && v3_reg) begin
            log_reg <= log_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_log_value = log_reg;

    // Checks
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline full and stalled");

    a_norm_msb: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !zero1_reg) |-> norm_w[31])
        else $error("normalized word lacks its top bit");

    a_out_from_stage3: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(v3_reg))
        else $error("output word appeared without a stage 3 word");

endmodule

/* sv/f2ql_lzc.sv */
// ----------------------------------------------------------------------------
// f2ql_lzc
// Leading-zero count of the mantissa as a 32-bit word, done as a byte
// select followed by a count inside the selected byte.
// ----------------------------------------------------------------------------
module f2ql_lzc
    import f2ql_pkg::*;
(
    input  logic [MANT_W-1:0] mant,
    output lzc_t              lz
);

    logic [31:0] word;
    logic [3:0]  byte_nz;
    logic [1:0]  grp_lz;
    logic [7:0]  sel_byte;
    logic [2:0]  byte_lz;
    logic        found;

    assign word = {1'b0, mant};

    // Which bytes hold a one
    always_comb begin
        for (int g = 0; g < 4; g++) begin
            byte_nz[g] = |word[8*g +: 8];
        end
    end

    // Topmost nonzero byte
    always_comb begin
        grp_lz   = 2'd3;
        sel_byte = word[7:0];
        if (byte_nz[3]) begin
            grp_lz   = 2'd0;
            sel_byte = word[31:24];
        end else if (byte_nz[2]) begin
            grp_lz   = 2'd1;
            sel_byte = word[23:16];
        end else if (byte_nz[1]) begin
            grp_lz   = 2'd2;
            sel_byte = word[15:8];
        end
    end

    // Count inside the byte, scanning from the top
    always_comb begin
        byte_lz = 3'd7;
        found   = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found && sel_byte[i]) begin
                byte_lz = 3'(7 - i);
                found   = 1'b1;
            end
        end
    end

    assign lz.zero  = ~|byte_nz;
    assign lz.count = {grp_lz, byte_lz};

endmodule
